// File: src/pqsb_pkg.sv
// ----------------------------------------------------------------------------
// pqsb_pkg
// Shared types and constants for the portal quad screen bounds block.
// ----------------------------------------------------------------------------
package pqsb_pkg;

  localparam int CoefW    = 32;                 // Q16.16 coefficient / coordinate
  localparam int ProdW    = 2 * CoefW;          // exact Q32.32 product
  localparam int ClipW    = 51;                 // exact clip sum, Q.16
  localparam int FracBits = 14;                 // Q2.14 screen fraction
  localparam int QBits    = FracBits + 1;       // quotient bits kept by the divider
  localparam int RemW     = ClipW + FracBits;   // divider partial remainder
  localparam int OutW     = 16;
  localparam int NumRows  = 3;
  localparam int NumTerms = 4;
  localparam int NumLanes = 4;
  localparam int DivLat   = QBits + 2;          // prep, one stage per bit, output
  localparam int LaneLat  = DivLat + 2;         // product stage and sum stage first

  localparam logic signed [OutW-1:0] OneQ14    = 16'sd16384;
  localparam logic signed [OutW-1:0] NegOneQ14 = -16'sd16384;
  localparam logic [ClipW-1:0]       EpsQ16    = ClipW'(32768);

  typedef enum logic [2:0] {
    REG_X_FIRST  = 3'd0,
    REG_X_SECOND = 3'd1,
    REG_Y_FIRST  = 3'd2,
    REG_Y_SECOND = 3'd3,
    REG_W_FIRST  = 3'd4,
    REG_W_SECOND = 3'd5
  } cfg_idx_t;

  // per-corner result handed from a lane to the merge stage
  typedef struct packed {
    logic                   behind;   // w <= 0
    logic                   near;     // -w below 0.5
    logic signed [OutW-1:0] sx;
    logic signed [OutW-1:0] sy;
  } lane_res_t;

endpackage

// File: src/portal_quad_screen_bounds_top.sv
// ----------------------------------------------------------------------------
// portal_quad_screen_bounds_top
// Screen bounding box of a wall opening projected through a view-projection.
// ----------------------------------------------------------------------------
// One opening is taken on every cycle (busy stays low) and its result appears
// on done after one input register, four corner lanes (a product stage, a
// sum stage and a 17-stage divider made of a prep stage, 15 stages that each
// resolve one quotient bit and an output stage), then the merge register.
// done is a one-cycle strobe and cannot be held off, so the receiver must
// capture the result in that cycle. Matrix registers may be written only
// while no item is in flight.
module portal_quad_screen_bounds_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pqsb_pkg::CoefW-1:0]   start_x,
  input  logic signed [pqsb_pkg::CoefW-1:0]   start_z,
  input  logic signed [pqsb_pkg::CoefW-1:0]   end_x,
  input  logic signed [pqsb_pkg::CoefW-1:0]   end_z,
  input  logic signed [pqsb_pkg::CoefW-1:0]   floor_level,
  input  logic signed [pqsb_pkg::CoefW-1:0]   ceiling_level,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [63:0]                         cfg_data,
  output logic                                done,
  output logic                                visible,
  output logic signed [pqsb_pkg::OutW-1:0]    box_min_x,
  output logic signed [pqsb_pkg::OutW-1:0]    box_min_y,
  output logic signed [pqsb_pkg::OutW-1:0]    box_max_x,
  output logic signed [pqsb_pkg::OutW-1:0]    box_max_y
);

  localparam int CF = pqsb_pkg::CoefW;
  localparam int NL = pqsb_pkg::NumLanes;
  localparam int LL = pqsb_pkg::LaneLat;

  logic [63:0] x_first, x_second, y_first, y_second, w_first, w_second;
  logic [pqsb_pkg::NumRows-1:0][pqsb_pkg::NumTerms-1:0][CF-1:0] coef;

  logic signed [CF-1:0] px [2];
  logic signed [CF-1:0] pz [2];
  logic signed [CF-1:0] hy [2];
  logic                 in_v;
  logic                 vld_d [LL];
  pqsb_pkg::lane_res_t [NL-1:0] lane_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_first  <= '0;
      x_second <= '0;
      y_first  <= '0;
      y_second <= '0;
      w_first  <= '0;
      w_second <= '0;
    end else if (cfg_we) begin
      case (pqsb_pkg::cfg_idx_t'(cfg_index))
        pqsb_pkg::REG_X_FIRST:  x_first  <= cfg_data;
        pqsb_pkg::REG_X_SECOND: x_second <= cfg_data;
        pqsb_pkg::REG_Y_FIRST:  y_first  <= cfg_data;
        pqsb_pkg::REG_Y_SECOND: y_second <= cfg_data;
        pqsb_pkg::REG_W_FIRST:  w_first  <= cfg_data;
        pqsb_pkg::REG_W_SECOND: w_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // term order per row: world x, height, world z, constant
  assign coef[0] = {x_second[31:0], x_second[63:32], x_first[31:0], x_first[63:32]};
  assign coef[1] = {y_second[31:0], y_second[63:32], y_first[31:0], y_first[63:32]};
  assign coef[2] = {w_second[31:0], w_second[63:32], w_first[31:0], w_first[63:32]};

  always_ff @(posedge clk) begin
    px[0] <= start_x;
    pz[0] <= start_z;
    px[1] <= end_x;
    pz[1] <= end_z;
    hy[0] <= floor_level;
    hy[1] <= ceiling_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
      for (int i = 0; i < LL; i++) vld_d[i] <= 1'b0;
    end else begin
      in_v     <= start && !busy;
      vld_d[0] <= in_v;
      for (int i = 1; i < LL; i++) vld_d[i] <= vld_d[i-1];
    end
  end

  // corner k: end point k[0], height k[1]
  for (genvar k = 0; k < NL; k++) begin : g_lane
    pqsb_lane u_lane (
      .clk  (clk),
      .x    (px[k % 2]),
      .h    (hy[k / 2]),
      .z    (pz[k % 2]),
      .coef (coef),
      .res  (lane_res[k])
    );
  end

  pqsb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_d[LL-1]),
    .lanes     (lane_res),
    .done      (done),
    .visible   (visible),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y)
  );

endmodule

// File: src/pqsb_div.sv
// ----------------------------------------------------------------------------
// pqsb_div
// Pipelined (c * 16384) / w, truncated toward zero, saturated to +-1.0.
// One quotient bit per stage; w is taken as positive.
// ----------------------------------------------------------------------------
module pqsb_div (
  input  logic                                clk,
  input  logic signed [pqsb_pkg::ClipW-1:0]   c,
  input  logic signed [pqsb_pkg::ClipW-1:0]   w,
  output logic signed [pqsb_pkg::OutW-1:0]    q
);

  localparam int CW = pqsb_pkg::ClipW;
  localparam int RW = pqsb_pkg::RemW;
  localparam int QB = pqsb_pkg::QBits;

  logic [CW:0]   mag_n;
  logic          sat_n;

  logic [RW-1:0] rem  [QB+1];
  logic [QB-1:0] quo  [QB+1];
  logic [CW-1:0] dvs  [QB+1];
  logic          neg  [QB+1];
  logic          sat  [QB+1];

  logic [QB-1:0]             qmag;
  logic signed [pqsb_pkg::OutW-1:0] qres;

  always_comb begin
    mag_n = c[CW-1] ? -{c[CW-1], c} : {c[CW-1], c};
    // |c| >= 2w means the quotient is at least 2.0
    sat_n = mag_n >= {w, 1'b0};
  end

  always_ff @(posedge clk) begin
    rem[0] <= RW'(mag_n) << pqsb_pkg::FracBits;
    quo[0] <= '0;
    dvs[0] <= w;
    neg[0] <= c[CW-1];
    sat[0] <= sat_n;
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RW-1:0] trial;
    assign trial = RW'(dvs[s]) << (QB - 1 - s);
    always_ff @(posedge clk) begin
      if (rem[s] >= trial) begin
        rem[s+1] <= rem[s] - trial;
        quo[s+1] <= {quo[s][QB-2:0], 1'b1};
      end else begin
        rem[s+1] <= rem[s];
        quo[s+1] <= {quo[s][QB-2:0], 1'b0};
      end
      dvs[s+1] <= dvs[s];
      neg[s+1] <= neg[s];
      sat[s+1] <= sat[s];
    end
  end

  always_comb begin
    if (sat[QB] || (quo[QB] > QB'(pqsb_pkg::OneQ14))) begin
      qmag = QB'(pqsb_pkg::OneQ14);
    end else begin
      qmag = quo[QB];
    end
    qres = neg[QB] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk) begin
    q <= qres;
  end

endmodule

// File: src/pqsb_lane.sv
// ----------------------------------------------------------------------------
// pqsb_lane
// One corner: three clip rows, a w test and two perspective divides.
// ----------------------------------------------------------------------------
module pqsb_lane (
  input  logic                                          clk,
  input  logic signed [pqsb_pkg::CoefW-1:0]             x,
  input  logic signed [pqsb_pkg::CoefW-1:0]             h,
  input  logic signed [pqsb_pkg::CoefW-1:0]             z,
  input  logic [pqsb_pkg::NumRows-1:0][pqsb_pkg::NumTerms-1:0][pqsb_pkg::CoefW-1:0] coef,
  output pqsb_pkg::lane_res_t                           res
);

  localparam int CW = pqsb_pkg::ClipW;
  localparam int PW = pqsb_pkg::ProdW;
  localparam int NR = pqsb_pkg::NumRows;
  localparam int DL = pqsb_pkg::DivLat;

  logic signed [PW-1:0] prod [NR][3];
  logic signed [CW-1:0] clip [NR];
  logic [CW-1:0]        negw;
  logic                 beh_d  [DL];
  logic                 near_d [DL];
  logic signed [pqsb_pkg::OutW-1:0] sx, sy;

  always_ff @(posedge clk) begin
    for (int r = 0; r < NR; r++) begin
      prod[r][0] <= $signed(coef[r][0]) * x;
      prod[r][1] <= $signed(coef[r][1]) * h;
      prod[r][2] <= $signed(coef[r][2]) * z;
    end
  end

  // dropping the low 16 bits floors each product to Q.16
  always_ff @(posedge clk) begin
    for (int r = 0; r < NR; r++) begin
      clip[r] <= CW'($signed(prod[r][0][PW-1:16])) + CW'($signed(prod[r][1][PW-1:16]))
               + CW'($signed(prod[r][2][PW-1:16])) + CW'($signed(coef[r][3]));
    end
  end

  assign negw = CW'(-clip[2]);

  always_ff @(posedge clk) begin
    beh_d[0]  <= (clip[2] <= 0);
    near_d[0] <= (negw < pqsb_pkg::EpsQ16);
    for (int i = 1; i < DL; i++) begin
      beh_d[i]  <= beh_d[i-1];
      near_d[i] <= near_d[i-1];
    end
  end

  pqsb_div u_div_x (.clk(clk), .c(clip[0]), .w(clip[2]), .q(sx));
  pqsb_div u_div_y (.clk(clk), .c(clip[1]), .w(clip[2]), .q(sy));

  always_comb begin
    res.behind = beh_d[DL-1];
    res.near   = near_d[DL-1];
    res.sx     = sx;
    res.sy     = sy;
  end

endmodule

// File: src/pqsb_merge.sv
// ----------------------------------------------------------------------------
// pqsb_merge
// Combines the four corner results into the screen box and visibility.
// ----------------------------------------------------------------------------
module pqsb_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  pqsb_pkg::lane_res_t [pqsb_pkg::NumLanes-1:0] lanes,
  output logic                                  done,
  output logic                                  visible,
  output logic signed [pqsb_pkg::OutW-1:0]      box_min_x,
  output logic signed [pqsb_pkg::OutW-1:0]      box_min_y,
  output logic signed [pqsb_pkg::OutW-1:0]      box_max_x,
  output logic signed [pqsb_pkg::OutW-1:0]      box_max_y
);

  localparam int OW = pqsb_pkg::OutW;

  logic          any_vis, any_behind, far_behind;
  logic signed [OW-1:0] mnx, mny, mxx, mxy;
  logic          vis_next;
  logic signed [OW-1:0] bx0_next, by0_next, bx1_next, by1_next;

  always_comb begin
    any_vis    = 1'b0;
    any_behind = 1'b0;
    far_behind = 1'b0;
    mnx = pqsb_pkg::OneQ14;
    mny = pqsb_pkg::OneQ14;
    mxx = pqsb_pkg::NegOneQ14;
    mxy = pqsb_pkg::NegOneQ14;
    for (int k = 0; k < pqsb_pkg::NumLanes; k++) begin
      if (lanes[k].behind) begin
        any_behind = 1'b1;
        if (!lanes[k].near) far_behind = 1'b1;
      end else begin
        any_vis = 1'b1;
        if (lanes[k].sx < mnx) mnx = lanes[k].sx;
        if (lanes[k].sx > mxx) mxx = lanes[k].sx;
        if (lanes[k].sy < mny) mny = lanes[k].sy;
        if (lanes[k].sy > mxy) mxy = lanes[k].sy;
      end
    end

    if ((any_vis && any_behind) || (!any_vis && any_behind && !far_behind)) begin
      vis_next = 1'b1;
      bx0_next = pqsb_pkg::NegOneQ14;
      by0_next = pqsb_pkg::NegOneQ14;
      bx1_next = pqsb_pkg::OneQ14;
      by1_next = pqsb_pkg::OneQ14;
    end else if (any_vis) begin
      vis_next = 1'b1;
      bx0_next = mnx;
      by0_next = mny;
      bx1_next = mxx;
      by1_next = mxy;
    end else begin
      vis_next = 1'b0;
      bx0_next = '0;
      by0_next = '0;
      bx1_next = '0;
      by1_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    visible   <= vis_next;
    box_min_x <= bx0_next;
    box_min_y <= by0_next;
    box_max_x <= bx1_next;
    box_max_y <= by1_next;
  end

endmodule
